// ----- rtl/brbc_pkg.sv -----
// Shared constants, types and index arithmetic of the chunked byte ring buffer.
package brbc_pkg;

    localparam int DEPTH       = 64;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int SIZE_W      = $clog2(DEPTH + 1);
    localparam int LEN_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] FILL_BYTE = 8'd46;
    localparam logic [SIZE_W-1:0] SIZE_MIN  = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(DEPTH);

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_DATA  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [0:0] {
        CFG_INDEX_ONLY  = 1'b0,
        CFG_SIZE_IN_USE = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        K_STATUS = 2'd0,
        K_WRITE  = 2'd1,
        K_READ   = 2'd2
    } t_kind;

    // One classified operation handed from the front to the back.
    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  addr;    // store address (write) or first address (read)
        logic [BYTE_W-1:0]  wbyte;
        logic [SIZE_W-1:0]  count;   // bytes to read, 0..size
        logic               err;
        logic [ADDR_W-1:0]  free;
        logic [ADDR_W-1:0]  filled;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0]  rbyte;
        logic               bvalid;
        logic               last;
        logic               err;
        logic [ADDR_W-1:0]  free;
        logic [ADDR_W-1:0]  filled;
    } t_result;

    function automatic logic [ADDR_W-1:0] f_filled(input logic [ADDR_W-1:0] wi,
                                                   input logic [ADDR_W-1:0] ri,
                                                   input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] v;
        if (wi < ri) v = SIZE_W'(wi) + s - SIZE_W'(ri);
        else         v = SIZE_W'(wi) - SIZE_W'(ri);
        return v[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] f_free(input logic [ADDR_W-1:0] filled,
                                                 input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] v;
        v = s - SIZE_W'(filled) - SIZE_W'(1);
        return v[ADDR_W-1:0];
    endfunction

    // (a + n) mod s for a < s and n <= s.
    function automatic logic [ADDR_W-1:0] f_wrap_add(input logic [ADDR_W-1:0] a,
                                                     input logic [SIZE_W-1:0] n,
                                                     input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] sum;
        sum = SIZE_W'(a) + n;
        if (sum >= s) sum = sum - s;
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] f_clamp_size(input logic [SIZE_W-1:0] v);
        if (v < SIZE_MIN) return SIZE_MIN;
        if (v > SIZE_MAX) return SIZE_MAX;
        return v;
    endfunction

endpackage

// ----- rtl/brbc_front.sv -----
// Front end: accepts items, keeps indices and chunk state, classifies each item.
module brbc_front import brbc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_opcode,
    input  logic [BYTE_W-1:0]   i_wbyte,
    input  logic [LEN_W-1:0]    i_len,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [SIZE_W-1:0]   i_cfg_data,
    output logic [SIZE_W-1:0]   o_size,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output t_cmd                o_cmd
);

    logic               r_index_only;
    logic [SIZE_W-1:0]  r_size;
    logic [ADDR_W-1:0]  r_wi, r_ri, r_cstart;
    logic [LEN_W-1:0]   r_total, r_pos;

    logic [ADDR_W-1:0]  n_wi, n_ri, n_cstart;
    logic [LEN_W-1:0]   n_total, n_pos;

    logic [ADDR_W-1:0]  w_filled_old, w_free_old, w_filled_new;
    logic [SIZE_W-1:0]  w_n;
    logic [LEN_W-1:0]   w_skip, w_offset;
    logic               w_accept;
    t_cmd               w_cmd;

    assign w_accept     = i_valid && i_cmd_ready;
    assign o_ready      = i_cmd_ready;
    assign o_cmd_valid  = i_valid;
    assign o_size       = r_size;

    assign w_filled_old = f_filled(r_wi, r_ri, r_size);
    assign w_free_old   = f_free(w_filled_old, r_size);
    assign w_n          = (i_len > LEN_W'(r_size)) ? r_size : i_len[SIZE_W-1:0];
    assign w_skip       = (r_total > LEN_W'(r_size)) ? r_total - LEN_W'(r_size) : '0;
    assign w_offset     = r_pos - w_skip;

    always_comb begin
        n_wi          = r_wi;
        n_ri          = r_ri;
        n_cstart      = r_cstart;
        n_total       = r_total;
        n_pos         = r_pos;
        w_cmd.kind    = K_STATUS;
        w_cmd.addr    = '0;
        w_cmd.wbyte   = i_wbyte;
        w_cmd.count   = w_n;
        w_cmd.err     = 1'b0;
        unique case (t_opcode'(i_opcode))
            OP_BEGIN: begin
                w_cmd.err = i_len > LEN_W'(w_free_old);
                n_cstart  = r_wi;
                n_total   = i_len;
                n_pos     = '0;
                n_wi      = f_wrap_add(r_wi, w_n, r_size);
            end
            OP_DATA: begin
                if (r_pos < r_total) begin
                    if (r_pos >= w_skip && !r_index_only) begin
                        w_cmd.kind = K_WRITE;
                        w_cmd.addr = f_wrap_add(r_cstart, w_offset[SIZE_W-1:0], r_size);
                    end
                    n_pos = r_pos + LEN_W'(1);
                end
            end
            OP_READ: begin
                w_cmd.err = i_len > LEN_W'(w_filled_old);
                n_ri      = f_wrap_add(r_ri, w_n, r_size);
                if (w_n != '0 && !r_index_only) begin
                    w_cmd.kind = K_READ;
                    w_cmd.addr = r_ri;
                end
            end
            OP_NONE: begin
            end
            default: begin
            end
        endcase
        w_filled_new  = f_filled(n_wi, n_ri, r_size);
        w_cmd.filled  = w_filled_new;
        w_cmd.free    = f_free(w_filled_new, r_size);
    end

    assign o_cmd = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_only <= 1'b0;
            r_size       <= SIZE_MAX;
            r_wi         <= '0;
            r_ri         <= '0;
            r_cstart     <= '0;
            r_total      <= '0;
            r_pos        <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_INDEX_ONLY: begin
                    r_index_only <= i_cfg_data[0];
                end
                CFG_SIZE_IN_USE: begin
                    r_size   <= f_clamp_size(i_cfg_data);
                    r_wi     <= '0;
                    r_ri     <= '0;
                    r_cstart <= '0;
                    r_total  <= '0;
                    r_pos    <= '0;
                end
                default: begin
                end
            endcase
        end else if (w_accept) begin
            r_wi     <= n_wi;
            r_ri     <= n_ri;
            r_cstart <= n_cstart;
            r_total  <= n_total;
            r_pos    <= n_pos;
        end
    end

endmodule

// ----- rtl/brbc_queue.sv -----
// Short command queue between the front end and the back end.
module brbc_queue import brbc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_cmd    i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_cmd    o_data
);

    t_cmd               r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp, r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    logic               w_push, w_pop;

    assign o_ready = r_cnt != QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_entry[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + QPTR_W'(1);
            if (w_pop)  r_rp <= r_rp + QPTR_W'(1);
            if (w_push && !w_pop)      r_cnt <= r_cnt + QCNT_W'(1);
            else if (w_pop && !w_push) r_cnt <= r_cnt - QCNT_W'(1);
        end
    end

endmodule

// ----- rtl/brbc_back.sv -----
// Back end: byte store, read sequencing and the registered result stage.
module brbc_back import brbc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [SIZE_W-1:0]   i_size,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  t_cmd                i_cmd,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output t_result             o_res
);

    logic [BYTE_W-1:0]  r_store [DEPTH];
    logic [DEPTH-1:0]   r_written;

    logic               r_active;
    logic [ADDR_W-1:0]  r_addr;
    logic [SIZE_W-1:0]  r_left;

    logic               r_s1_valid, r_s1_read, r_s1_last, r_s1_err;
    logic [ADDR_W-1:0]  r_s1_free, r_s1_filled;
    logic [BYTE_W-1:0]  r_rd_data;
    logic               r_rd_written;

    logic               r_out_valid;
    t_result            r_out;

    logic               w_s1_move, w_s1_free, w_issue, w_is_read, w_last;
    logic [SIZE_W-1:0]  w_left;
    logic [ADDR_W-1:0]  w_addr, w_addr_nxt;

    assign w_s1_move   = r_s1_valid && (!r_out_valid || i_res_ready);
    assign w_s1_free   = !r_s1_valid || w_s1_move;
    assign w_is_read   = i_cmd.kind == K_READ;
    assign w_left      = r_active ? r_left : i_cmd.count;
    assign w_addr      = r_active ? r_addr : i_cmd.addr;
    assign w_last      = !w_is_read || (w_left == SIZE_W'(1));
    assign w_issue     = i_cmd_valid && w_s1_free;
    assign o_cmd_ready = w_s1_free && w_last;
    assign w_addr_nxt  = (SIZE_W'(w_addr) + SIZE_W'(1) == i_size) ? '0
                                                                  : w_addr + ADDR_W'(1);

    // Store port: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_issue && i_cmd.kind == K_WRITE) begin
            r_store[i_cmd.addr] <= i_cmd.wbyte;
        end
        if (w_issue) begin
            r_rd_data <= r_store[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (w_issue && i_cmd.kind == K_WRITE) begin
            r_written[i_cmd.addr] <= 1'b1;
        end
    end

    // Read sequencer and issue stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_issue) r_active <= !w_last;
            if (w_issue)        r_s1_valid <= 1'b1;
            else if (w_s1_move) r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_addr       <= w_addr_nxt;
            r_left       <= w_left - SIZE_W'(1);
            r_rd_written <= r_written[w_addr];
            r_s1_read    <= w_is_read;
            r_s1_last    <= w_last;
            r_s1_err     <= i_cmd.err;
            r_s1_free    <= i_cmd.free;
            r_s1_filled  <= i_cmd.filled;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out.rbyte  <= r_s1_read ? (r_rd_written ? r_rd_data : FILL_BYTE) : '0;
            r_out.bvalid <= r_s1_read;
            r_out.last   <= r_s1_last;
            r_out.err    <= r_s1_err;
            r_out.free   <= r_s1_free;
            r_out.filled <= r_s1_filled;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ----- rtl/byte_ring_buffer_chunked.sv -----
// Top level of the chunked byte ring buffer: front end, command queue, back end.
//
//  channel   direction  handshake                      contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: write_byte, chunk_length;
//                                                      tuser: opcode
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: read_byte, space_error,
//                                                      space_free, space_filled;
//                                                      tuser: byte_valid; tlast: last
//  cfg       in         i_cfg_we (no wait)             0 index_only, 1 size_in_use
//
// Begin, data-byte and status items may arrive every cycle while s_axis_tready is high.
// A read chunk of n bytes holds the back end for n store reads, one per unstalled cycle.
// The first result passes the command queue, the issue stage, then the output register.
// A stalled m_axis fills the four-entry command queue, then drops s_axis_tready.
// Synchronous active-low reset; the store reads as 46 until a slot is first written.
module byte_ring_buffer_chunked import brbc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,   // [7:0] write_byte, [23:8] chunk_length
    input  logic [1:0]          s_axis_tuser,   // [1:0] opcode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,   // [7:0] read_byte, [8] space_error,
                                                // [14:9] space_free, [20:15] space_filled
    output logic [0:0]          m_axis_tuser,   // [0] byte_valid
    output logic                m_axis_tlast,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [SIZE_W-1:0]   i_cfg_data
);

    logic               w_fq_valid, w_fq_ready;
    t_cmd               w_fq_cmd;
    logic               w_qb_valid, w_qb_ready;
    t_cmd               w_qb_cmd;
    logic [SIZE_W-1:0]  w_size;
    t_result            w_res;

    // Classify items and advance indices at accept time.
    brbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_wbyte     (s_axis_tdata[7:0]),
        .i_len       (s_axis_tdata[23:8]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_size      (w_size),
        .o_cmd_valid (w_fq_valid),
        .i_cmd_ready (w_fq_ready),
        .o_cmd       (w_fq_cmd)
    );

    // Hold classified commands while the back end works through a read chunk.
    brbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .i_data  (w_fq_cmd),
        .o_valid (w_qb_valid),
        .i_ready (w_qb_ready),
        .o_data  (w_qb_cmd)
    );

    // Write and read the store, emit one result per cycle while m_axis_tready is high.
    brbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (w_size),
        .i_cmd_valid (w_qb_valid),
        .o_cmd_ready (w_qb_ready),
        .i_cmd       (w_qb_cmd),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tdata = {3'b000, w_res.filled, w_res.free, w_res.err, w_res.rbyte};
    assign m_axis_tuser = w_res.bvalid;
    assign m_axis_tlast = w_res.last;

endmodule
